>>> src/aes_pkg.sv
package aes_pkg;

  localparam int BlockW = 128;
  localparam int HalfW = 64;
  localparam int NumRounds = 10;

  typedef enum logic [0:0] {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_t;

  localparam int CfgIdxW = 1;

  // control that travels with a block down the round chain
  typedef struct packed {
    logic valid;
    logic decrypt;
  } aes_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd0: v = 8'h01;
      4'd1: v = 8'h02;
      4'd2: v = 8'h04;
      4'd3: v = 8'h08;
      4'd4: v = 8'h10;
      4'd5: v = 8'h20;
      4'd6: v = 8'h40;
      4'd7: v = 8'h80;
      4'd8: v = 8'h1b;
      4'd9: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit state, byte 0 most significant
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] s, input int i);
    return s[BlockW-1-8*i -: 8];
  endfunction

  // one step of the key schedule
  function automatic logic [BlockW-1:0] next_key(input logic [BlockW-1:0] k,
                                                  input logic [3:0] r);
    logic [7:0] c [16];
    logic [7:0] n [16];
    logic [BlockW-1:0] o;
    for (int i = 0; i < 16; i++) c[i] = get_byte(k, i);
    n[0] = c[0] ^ sbox(c[13]) ^ rcon(r);
    n[1] = c[1] ^ sbox(c[14]);
    n[2] = c[2] ^ sbox(c[15]);
    n[3] = c[3] ^ sbox(c[12]);
    for (int j = 4; j < 16; j++) n[j] = c[j] ^ n[j-4];
    for (int i = 0; i < 16; i++) o[BlockW-1-8*i -: 8] = n[i];
    return o;
  endfunction

endpackage

>>> src/aes_round_cell.sv
// one cipher round; key selected by direction, block and control registered
module aes_round_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  aes_pkg::aes_ctl_t         ctl_in,
  input  logic [aes_pkg::BlockW-1:0] state_in,
  input  logic [aes_pkg::BlockW-1:0] enc_key,
  input  logic [aes_pkg::BlockW-1:0] dec_key,
  input  logic                      enc_last,
  input  logic                      dec_last,
  output aes_pkg::aes_ctl_t         ctl_out,
  output logic [aes_pkg::BlockW-1:0] state_out
);
  import aes_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] a, b, c2, d3;
  logic [7:0] a2, a4, a8, b2, b4, b8, c22, c24, c28, d2, d4, d8;
  logic [BlockW-1:0] state_next;

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = get_byte(state_in, i);
    if (ctl_in.decrypt) begin
      // inverse shift rows, inverse sub bytes, add key, inverse mix columns
      for (int cc = 0; cc < 4; cc++)
        for (int w = 0; w < 4; w++)
          t[((cc + w) % 4) * 4 + w] = inv_sbox(s[cc*4 + w]);
      for (int i = 0; i < 16; i++) t[i] = t[i] ^ get_byte(dec_key, i);
      for (int cc = 0; cc < 4; cc++) begin
        a = t[cc*4]; b = t[cc*4+1]; c2 = t[cc*4+2]; d3 = t[cc*4+3];
        a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
        b2 = xtime(b); b4 = xtime(b2); b8 = xtime(b4);
        c22 = xtime(c2); c24 = xtime(c22); c28 = xtime(c24);
        d2 = xtime(d3); d4 = xtime(d2); d8 = xtime(d4);
        m[cc*4]   = (a8^a4^a2) ^ (b8^b2^b) ^ (c28^c24^c2) ^ (d8^d3);
        m[cc*4+1] = (a8^a) ^ (b8^b4^b2) ^ (c28^c22^c2) ^ (d8^d4^d3);
        m[cc*4+2] = (a8^a4^a) ^ (b8^b) ^ (c28^c24^c22) ^ (d8^d2^d3);
        m[cc*4+3] = (a8^a2^a) ^ (b8^b4^b) ^ (c28^c2) ^ (d8^d4^d2);
      end
      if (dec_last) m = t;
    end else begin
      a = '0; b = '0; c2 = '0; d3 = '0;
      a2 = '0; a4 = '0; a8 = '0; b2 = '0; b4 = '0; b8 = '0;
      c22 = '0; c24 = '0; c28 = '0; d2 = '0; d4 = '0; d8 = '0;
      for (int cc = 0; cc < 4; cc++)
        for (int w = 0; w < 4; w++)
          t[cc*4 + w] = sbox(s[((cc + w) % 4) * 4 + w]);
      for (int cc = 0; cc < 4; cc++) begin
        m[cc*4]   = xtime(t[cc*4]) ^ xtime(t[cc*4+1]) ^ t[cc*4+1] ^ t[cc*4+2] ^ t[cc*4+3];
        m[cc*4+1] = t[cc*4] ^ xtime(t[cc*4+1]) ^ xtime(t[cc*4+2]) ^ t[cc*4+2] ^ t[cc*4+3];
        m[cc*4+2] = t[cc*4] ^ t[cc*4+1] ^ xtime(t[cc*4+2]) ^ xtime(t[cc*4+3]) ^ t[cc*4+3];
        m[cc*4+3] = xtime(t[cc*4]) ^ t[cc*4] ^ t[cc*4+1] ^ t[cc*4+2] ^ xtime(t[cc*4+3]);
      end
      if (enc_last) m = t;
      for (int i = 0; i < 16; i++) m[i] = m[i] ^ get_byte(enc_key, i);
    end
    for (int i = 0; i < 16; i++) state_next[BlockW-1-8*i -: 8] = m[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    state_out <= state_next;
  end

endmodule

>>> src/aes_key_sched.sv
// key schedule: one round key per cycle while busy, kept in a register store
module aes_key_sched (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [aes_pkg::BlockW-1:0] key,
  output logic                       done,
  output logic [aes_pkg::BlockW-1:0] round_keys [aes_pkg::NumRounds+1]
);
  import aes_pkg::*;

  logic [3:0]        step;
  logic              running;
  logic [BlockW-1:0] cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
    end else if (load) begin
      running <= 1'b1;
      step    <= '0;
      done    <= 1'b0;
    end else if (running) begin
      step <= step + 4'd1;
      if (step == 4'(NumRounds - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
    if (load) begin
      cur           <= key;
      round_keys[0] <= key;
    end else if (running) begin
      cur                   <= next_key(cur, step);
      round_keys[step + 1'b1] <= next_key(cur, step);
    end
  end

`ifndef SYNTH
  a_done_not_running: assert property (@(posedge clk) disable iff (rst)
    done |-> !running) else $error("schedule done while running");
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    load |=> running && !done) else $error("load did not start schedule");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    (running && step == 4'(NumRounds - 1) && !load) |=> done)
    else $error("schedule did not finish");
`endif

endmodule

>>> src/aes128_block_cipher_top.sv
// channel | handshake          | payload
// cfg     | cfg_valid/ready    | cfg_index, cfg_data
// in      | start & !busy      | command, block_high, block_low
// out     | result_valid       | result_high, result_low
//
// one block enters per cycle unless busy; each round cell registers the result
// the first block after reset or a key write waits while the key
// schedule produces one round key per cycle; busy is high during that time
// reset clears the key registers and marks the round keys stale
// results cannot be stalled; each shows for one cycle with result_valid
module aes128_block_cipher_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic                 command,
  input  logic [63:0]          block_high,
  input  logic [63:0]          block_low,
  output logic                 result_valid,
  output logic [63:0]          result_high,
  output logic [63:0]          result_low
);
  import aes_pkg::*;

  logic [HalfW-1:0]  key_high, key_low;
  logic              keys_ready;
  logic              sched_load, sched_done, sched_pending;
  logic [BlockW-1:0] round_keys [NumRounds+1];
  logic              held;
  logic              held_cmd;
  logic [BlockW-1:0] held_block;
  aes_ctl_t          ctl [NumRounds+1];
  logic [BlockW-1:0] st  [NumRounds+1];
  logic              accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  // busy while a block waits for keys
  assign busy      = held;
  assign sched_load = accept && !keys_ready && !sched_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high      <= '0;
      key_low       <= '0;
      keys_ready    <= 1'b0;
      sched_pending <= 1'b0;
      held          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_KEY_HIGH: key_high <= cfg_data;
          REG_KEY_LOW:  key_low  <= cfg_data;
          default: ;
        endcase
        keys_ready <= 1'b0;
      end
      if (sched_load) sched_pending <= 1'b1;
      if (sched_pending && sched_done && !sched_load) begin
        sched_pending <= 1'b0;
        keys_ready    <= 1'b1;
      end
      if (accept && !keys_ready) held <= 1'b1;
      else if (held && sched_pending && sched_done) held <= 1'b0;
    end
    if (accept) begin
      held_cmd   <= command;
      held_block <= {block_high, block_low};
    end
  end

  // head of the chain: initial key add, from input or from a held block
  always_comb begin
    logic [BlockW-1:0] b;
    logic              d;
    if (held) begin
      b = held_block; d = held_cmd;
      ctl[0].valid = sched_pending && sched_done;
    end else begin
      b = {block_high, block_low}; d = command;
      ctl[0].valid = accept && keys_ready;
    end
    ctl[0].decrypt = d;
    st[0] = b ^ (d ? round_keys[NumRounds] : round_keys[0]);
  end

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl_in    (ctl[r-1]),
      .state_in  (st[r-1]),
      .enc_key   (round_keys[r]),
      .dec_key   (round_keys[NumRounds-r]),
      .enc_last  (r == NumRounds),
      .dec_last  (r == NumRounds),
      .ctl_out   (ctl[r]),
      .state_out (st[r])
    );
  end

  aes_key_sched u_sched (
    .clk        (clk),
    .rst        (rst),
    .load       (sched_load),
    .key        ({key_high, key_low}),
    .done       (sched_done),
    .round_keys (round_keys)
  );

  assign result_valid = ctl[NumRounds].valid;
  assign result_high  = st[NumRounds][BlockW-1:HalfW];
  assign result_low   = st[NumRounds][HalfW-1:0];

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    held |-> !keys_ready) else $error("block held with keys ready");
  a_release: assert property (@(posedge clk) disable iff (rst)
    (held && sched_pending && sched_done) |=> !held && ctl[1].valid)
    else $error("held block not released");
  a_pending_hold: assert property (@(posedge clk) disable iff (rst)
    held |-> sched_pending) else $error("held block without schedule");
`endif

endmodule

>>> dv/tb_aes128_block_cipher_top.sv
module tb_aes128_block_cipher_top;
  import aes_pkg::*;

  // one block beat as the driver sees it
  typedef struct packed {
    cmd_t        op;
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_beat_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_res_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        start;
  logic        busy;
  logic        command;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        result_valid;
  logic [63:0] result_high;
  logic [63:0] result_low;

  aes128_block_cipher_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .command(command),
    .block_high(block_high), .block_low(block_low),
    .result_valid(result_valid), .result_high(result_high), .result_low(result_low)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // predictor state: current key and its expanded schedule
  logic [63:0]  key_hi, key_lo;
  logic [127:0] sched [11];
  logic         sched_ok;

  blk_beat_t pending_blocks [$];
  blk_res_t  expected_blocks [$];
  int        errors;
  int        cycles;
  localparam int CycleLimit = 2000000;

  function automatic logic [7:0] fsub(input logic [7:0] x);
    logic [7:0] s;
    logic [7:0] r;
    // forward s-box as multiplicative inverse plus affine map
    r = 8'h00;
    if (x != 8'h00) begin
      for (int c = 1; c < 256; c++) begin
        if (gmul(x, c[7:0]) == 8'h01) r = c[7:0];
      end
    end
    s = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]} ^ 8'h63;
    return s;
  endfunction

  function automatic logic [7:0] dbl8(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = dbl8(a);
    end
    return p;
  endfunction

  // tables built once at time zero
  logic [7:0] fwd_tab [256];
  logic [7:0] inv_tab [256];

  function automatic logic [127:0] pack16(input logic [7:0] b [16]);
    logic [127:0] v;
    for (int i = 0; i < 16; i++) v[127-8*i -: 8] = b[i];
    return v;
  endfunction

  task automatic expand_schedule();
    logic [7:0] c [16];
    logic [7:0] n [16];
    logic [7:0] rc;
    sched[0] = {key_hi, key_lo};
    rc = 8'h01;
    for (int i = 0; i < 16; i++) c[i] = sched[0][127-8*i -: 8];
    for (int r = 1; r <= 10; r++) begin
      n[0] = c[0] ^ fwd_tab[c[13]] ^ rc;
      n[1] = c[1] ^ fwd_tab[c[14]];
      n[2] = c[2] ^ fwd_tab[c[15]];
      n[3] = c[3] ^ fwd_tab[c[12]];
      for (int j = 4; j < 16; j++) n[j] = c[j] ^ n[j-4];
      sched[r] = pack16(n);
      c = n;
      rc = dbl8(rc);
    end
    sched_ok = 1'b1;
  endtask

  task automatic predict_block(input blk_beat_t b, output blk_res_t res);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] v;
    if (!sched_ok) expand_schedule();
    v = {b.hi, b.lo};
    for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
    if (b.op == CMD_ENCRYPT) begin
      for (int i = 0; i < 16; i++) s[i] ^= sched[0][127-8*i -: 8];
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) s[i] = fwd_tab[s[i]];
        // shift rows
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) t[c*4+w] = s[((c+w)%4)*4+w];
        s = t;
        if (r < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
            s[c*4]   = dbl8(a0) ^ dbl8(a1) ^ a1 ^ a2 ^ a3;
            s[c*4+1] = a0 ^ dbl8(a1) ^ dbl8(a2) ^ a2 ^ a3;
            s[c*4+2] = a0 ^ a1 ^ dbl8(a2) ^ dbl8(a3) ^ a3;
            s[c*4+3] = dbl8(a0) ^ a0 ^ a1 ^ a2 ^ dbl8(a3);
          end
        end
        for (int i = 0; i < 16; i++) s[i] ^= sched[r][127-8*i -: 8];
      end
    end else begin
      for (int i = 0; i < 16; i++) s[i] ^= sched[10][127-8*i -: 8];
      for (int r = 9; r >= 0; r--) begin
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) t[((c+w)%4)*4+w] = s[c*4+w];
        for (int i = 0; i < 16; i++) s[i] = inv_tab[t[i]];
        for (int i = 0; i < 16; i++) s[i] ^= sched[r][127-8*i -: 8];
        if (r > 0) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
            s[c*4]   = gmul(a0,14) ^ gmul(a1,11) ^ gmul(a2,13) ^ gmul(a3,9);
            s[c*4+1] = gmul(a0,9) ^ gmul(a1,14) ^ gmul(a2,11) ^ gmul(a3,13);
            s[c*4+2] = gmul(a0,13) ^ gmul(a1,9) ^ gmul(a2,14) ^ gmul(a3,11);
            s[c*4+3] = gmul(a0,11) ^ gmul(a1,13) ^ gmul(a2,9) ^ gmul(a3,14);
          end
        end
      end
    end
    v = pack16(s);
    res.hi = v[127:64];
    res.lo = v[63:0];
  endtask

  // accepted beat seen at the rising edge; the driver reads it at the next falling edge
  logic busy_at_edge;

  // driver: takes blocks from the pending queue, with random gaps between some of them
  int gap_left;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy_at_edge) begin
      // last beat went in at the rising edge; pick the next one
      if (pending_blocks.size() > 0 && (cycles % 3 == 0 ? 1'b1 : $urandom_range(0, 1))) begin
        if ($urandom_range(0, 3) == 0 && gap_left == 0) begin
          start <= 1'b0;
          gap_left <= $urandom_range(0, 19);
        end else begin
          start <= 1'b1;
          {command, block_high, block_low} <= pending_blocks.pop_front();
        end
      end else begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 19);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_blocks.size() > 0) begin
        start <= 1'b1;
        {command, block_high, block_low} <= pending_blocks.pop_front();
      end
    end
  end

  always @(posedge clk) begin
    busy_at_edge <= busy;
    cycles <= cycles + 1;
    if (!rst && start && !busy) begin
      blk_res_t r;
      predict_block('{op: cmd_t'(command), hi: block_high, lo: block_low}, r);
      expected_blocks.push_back(r);
    end
  end

  // monitor: results cannot be held off, so every strobe is checked
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: result with nothing expected: %h %h", $time, result_high, result_low);
        errors++;
      end else begin
        blk_res_t e;
        e = expected_blocks.pop_front();
        if (result_high !== e.hi) begin
          $display("%0t: result_high expected %h actual %h", $time, e.hi, result_high);
          errors++;
        end
        if (result_low !== e.lo) begin
          $display("%0t: result_low expected %h actual %h", $time, e.lo, result_low);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("tb_aes128_block_cipher_top: FAIL");
      $finish;
    end
  end

  task automatic write_key_reg(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_KEY_HIGH) key_hi = val;
    else key_lo = val;
    sched_ok = 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block drained means nothing queued, nothing in flight, then a margin
  task automatic wait_drained();
    while (pending_blocks.size() > 0 || start || expected_blocks.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge64();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h1;
      default: return rand64();
    endcase
  endfunction

  task automatic queue_block(input cmd_t op, input logic [63:0] hi, input logic [63:0] lo);
    pending_blocks.push_back('{op: op, hi: hi, lo: lo});
  endtask

  initial begin
    logic [127:0] pt;
    for (int i = 0; i < 256; i++) fwd_tab[i] = fsub(i[7:0]);
    for (int i = 0; i < 256; i++) inv_tab[fwd_tab[i]] = i[7:0];
    errors = 0;
    cycles = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_KEY_HIGH;
    cfg_data = '0;
    start = 1'b0;
    command = CMD_ENCRYPT;
    block_high = '0;
    block_low = '0;
    busy_at_edge = 1'b0;
    key_hi = '0;
    key_lo = '0;
    sched_ok = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: all-zero key after reset, field extremes, both operations
    queue_block(CMD_ENCRYPT, 64'h0, 64'h0);
    queue_block(CMD_DECRYPT, 64'h0, 64'h0);
    queue_block(CMD_ENCRYPT, '1, '1);
    queue_block(CMD_DECRYPT, '1, '1);
    wait_drained();
    // standard test vector key, then its plaintext both ways
    write_key_reg(REG_KEY_HIGH, 64'h0001_0203_0405_0607);
    write_key_reg(REG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
    queue_block(CMD_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    queue_block(CMD_DECRYPT, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    queue_block(CMD_ENCRYPT, 64'h8000_0000_0000_0000, 64'h1);
    queue_block(CMD_DECRYPT, 64'h1, 64'h8000_0000_0000_0000);
    wait_drained();
    // extreme keys; key write with only one half changed
    write_key_reg(REG_KEY_HIGH, '1);
    write_key_reg(REG_KEY_LOW, '1);
    queue_block(CMD_ENCRYPT, 64'h0, '1);
    queue_block(CMD_DECRYPT, '1, 64'h0);
    wait_drained();
    write_key_reg(REG_KEY_LOW, 64'h0);
    queue_block(CMD_ENCRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    queue_block(CMD_DECRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    wait_drained();

    // random phases, each under a fresh key
    for (int ph = 0; ph < 11; ph++) begin
      write_key_reg(REG_KEY_HIGH, edge64());
      write_key_reg(REG_KEY_LOW, edge64());
      for (int n = 0; n < 100; n++) begin
        queue_block(cmd_t'($urandom_range(0, 1)),
                    ($urandom_range(0, 9) == 0) ? edge64() : rand64(),
                    ($urandom_range(0, 9) == 0) ? edge64() : rand64());
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("tb_aes128_block_cipher_top: PASS");
    end else begin
      $display("tb_aes128_block_cipher_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/aes_pkg.sv
src/aes_round_cell.sv
src/aes_key_sched.sv
src/aes128_block_cipher_top.sv
dv/tb_aes128_block_cipher_top.sv
